>>> hdl/modbus_rtu_request_receiver_defines.svh
// Assertion macros shared by the request receiver modules
`ifndef MODBUS_RTU_REQUEST_RECEIVER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_RECEIVER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define MRR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define MRR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mrr_pkg.sv
// Types, constants and CRC helper for the Modbus RTU request receiver
package mrr_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int STEP_W      = $clog2(FRAME_BYTES);
	// last frame byte that is kept (bytes 1..5 feed the result fields)
	localparam int DATA_LAST   = FRAME_BYTES - 3;

	localparam logic [STEP_W-1:0] STEP_IDLE   = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_CRC_LO = STEP_W'(FRAME_BYTES - 2);
	localparam logic [STEP_W-1:0] STEP_CRC_HI = STEP_W'(FRAME_BYTES - 1);

	localparam logic [2:0] EV_READ  = 3'd0;
	localparam logic [2:0] EV_WRITE = 3'd1;
	localparam logic [2:0] EV_OTHER = 3'd2;
	localparam logic [2:0] EV_CRC   = 3'd3;
	localparam logic [2:0] EV_ZERO  = 3'd4;

	localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FUNC_READ_INPUT   = 8'd4;
	localparam logic [7:0] FUNC_WRITE_SINGLE = 8'd6;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] READ_COUNT_1  = 16'h0001;
	localparam logic [7:0]  SLAVE_ID_RST  = 8'd1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       line_quiet;
		logic       tx_busy;
	} mrr_req_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  function_code;
		logic [15:0] register_address;
		logic [15:0] data_value;
	} mrr_res_t;

	// reflected CRC-16, one byte, bit at a time
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/mrr_frame.sv
// Frame tracker: byte position, CRC accumulation, stored fields and classification
`include "modbus_rtu_request_receiver_defines.svh"

module mrr_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  mrr_pkg::mrr_req_t req,
	input  logic [7:0]        slave_id,
	output logic              hit,
	output mrr_pkg::mrr_res_t res
);
	import mrr_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [15:0]       crc_q;
	logic [15:0]       crc_d;
	logic [7:0]        byte_q [1:DATA_LAST];
	logic [15:0]       addr;
	logic [15:0]       data;
	logic [2:0]        ev;

	assign addr = {byte_q[2], byte_q[3]};
	assign data = {byte_q[4], byte_q[5]};

	// classification of a frame whose CRC checked out
	always_comb begin
		if (addr == 16'h0000) begin
			ev = EV_ZERO;
		end else if (byte_q[1] inside {FUNC_READ_HOLDING, FUNC_READ_INPUT}) begin
			ev = (data == READ_COUNT_1) ? EV_READ : EV_OTHER;
		end else if (byte_q[1] == FUNC_WRITE_SINGLE) begin
			ev = EV_WRITE;
		end else begin
			ev = EV_OTHER;
		end
	end

	always_comb begin
		step_d               = step_q;
		crc_d                = crc_q;
		hit                  = 1'b0;
		res.event_res        = EV_CRC;
		res.function_code    = byte_q[1];
		res.register_address = addr;
		res.data_value       = data;
		case (step_q)
			STEP_IDLE: begin
				if (req.line_quiet && !req.tx_busy && req.rx_byte == slave_id) begin
					crc_d  = crc_byte(CRC_INIT, req.rx_byte);
					step_d = step_q + STEP_W'(1);
				end
			end
			STEP_CRC_LO: begin
				if (crc_q[7:0] != req.rx_byte) begin
					hit    = 1'b1;
					step_d = STEP_IDLE;
					crc_d  = CRC_INIT;
				end else begin
					step_d = STEP_CRC_HI;
				end
			end
			STEP_CRC_HI: begin
				hit    = 1'b1;
				step_d = STEP_IDLE;
				crc_d  = CRC_INIT;
				if (crc_q[15:8] == req.rx_byte) begin
					res.event_res = ev;
				end
			end
			default: begin
				crc_d  = crc_byte(crc_q, req.rx_byte);
				step_d = step_q + STEP_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			crc_q  <= CRC_INIT;
		end else if (en) begin
			step_q <= step_d;
			crc_q  <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i <= DATA_LAST; i++) begin
			if (en && step_q == STEP_W'(i)) begin
				byte_q[i] <= req.rx_byte;
			end
		end
	end

	`MRR_ASSERT_IMP(a_hit_at_crc, hit, step_q == STEP_CRC_LO || step_q == STEP_CRC_HI, "result outside CRC bytes")
	`MRR_ASSERT_NXT(a_idle_after_hit, en && hit, step_q == STEP_IDLE && crc_q == CRC_INIT, "no return to idle")
	`MRR_ASSERT_NXT(a_hold_when_off, !en, $stable(step_q) && $stable(crc_q), "state moved while held")

endmodule

>>> hdl/modbus_rtu_request_receiver.sv
// Throughput: one request per cycle; requests stall only while a result waits.
// Frame bytes pass through an input register, then CRC and step logic into the result register.
// Reset clears valids, frame step, CRC (0xFFFF) and slave id (1); stored bytes are not reset.
`include "modbus_rtu_request_receiver_defines.svh"

module modbus_rtu_request_receiver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  mrr_pkg::mrr_req_t req_data,
	output logic              res_valid,
	input  logic              res_stall,
	output mrr_pkg::mrr_res_t res_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import mrr_pkg::*;

	logic     req_valid_s1;
	mrr_req_t req_s1;
	logic     res_valid_q;
	mrr_res_t res_q;
	logic     [7:0] slave_id_q;
	logic     advance;
	logic     fire;
	logic     hit;
	mrr_res_t res;

	assign cfg_ready = 1'b1;
	assign advance   = !res_valid_q || !res_stall;
	assign fire      = req_valid_s1 && advance;
	assign req_stall = req_valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= SLAVE_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			slave_id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (!req_stall) begin
				req_valid_s1 <= req_valid;
			end
			if (advance) begin
				res_valid_q <= fire && hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
		if (fire && hit) begin
			res_q <= res;
		end
	end

	mrr_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (fire),
		.req      (req_s1),
		.slave_id (slave_id_q),
		.hit      (hit),
		.res      (res)
	);

	`MRR_ASSERT_NXT(a_s1_held, req_valid_s1 && !fire, req_valid_s1 && $stable(req_s1), "request lost in s1")
	`MRR_ASSERT_NXT(a_res_from_s1, fire && hit, res_valid_q && res_q == $past(res), "result not captured")
	`MRR_ASSERT_IMP(a_event_range, res_valid_q, res_q.event_res <= EV_ZERO, "bad event code")

endmodule

>>> tb/modbus_rtu_request_receiver_tb.sv
// Testbench for the Modbus RTU request receiver: directed frames from a table, then random frames
module modbus_rtu_request_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mrr_pkg::*;

	localparam int SETTLE_CYCLES = 4;	// the last byte passes the input register, then the result register
	localparam int IDLE_LIMIT    = 1000;	// far beyond gap + stall + settle of a good run
	localparam int PHASES        = 5;
	localparam int PHASE_BYTES   = 175;
	localparam int MAX_WAIT      = 11;
	localparam int REPORT_MAX    = 10;
	localparam int DIR_ROWS      = 26;

	typedef enum logic [1:0] {SRC_LITERAL, SRC_CRC_LO, SRC_CRC_HI} byte_src_t;
	typedef enum logic [1:0] {FAULT_NONE, FAULT_CRC_LO, FAULT_CRC_HI} crc_fault_t;

	// on CRC rows the byte column is an xor mask applied to the running CRC byte
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       line_quiet;
		logic       tx_busy;
		byte_src_t  src;
		logic       typed;
		mrr_res_t   res;
	} dir_row_t;

	localparam mrr_res_t NO_RES = '0;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// starts refused: line busy, reply in progress, foreign station
		'{8'h01, 1'b0, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h01, 1'b1, 1'b1, SRC_LITERAL, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		// read of address zero, line state toggling mid-frame
		'{8'h01, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{FUNC_READ_HOLDING, 1'b0, 1'b1, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b1, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h01, 1'b0, 1'b1, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, SRC_CRC_LO, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, SRC_CRC_HI, 1'b1,
			{EV_ZERO, FUNC_READ_HOLDING, 16'h0000, READ_COUNT_1}},
		// all ones, low CRC byte wrong
		'{8'h01, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b0, SRC_CRC_LO, 1'b1, {EV_CRC, 8'hFF, 16'hFFFF, 16'hFFFF}},
		// write, high CRC byte wrong
		'{8'h01, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{FUNC_WRITE_SINGLE, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h12, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h34, 1'b1, 1'b0, SRC_LITERAL, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, SRC_CRC_LO, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, SRC_CRC_HI, 1'b1,
			{EV_CRC, FUNC_WRITE_SINGLE, 16'h8000, 16'h1234}}
	};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	mrr_req_t req_data = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	mrr_res_t res_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	// frame decoder state
	logic [7:0]        station_id = SLAVE_ID_RST;
	logic [STEP_W-1:0] frame_pos = STEP_IDLE;
	logic [7:0]        frame_buf [FRAME_BYTES];
	logic [15:0]       crc_acc = CRC_INIT;

	// shape of the random frame being sent
	crc_fault_t frame_fault = FAULT_NONE;
	bit         zero_addr;
	bit         single_count;

	mrr_res_t expected_events [$];
	int       fail_count = 0;
	int       bytes_in_frames = 0;
	int       res_hold = 0;
	bit       pace_on = 1'b1;

	modbus_rtu_request_receiver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_shift(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// advances the frame by one byte; returns 1 when the byte closes a frame
	function automatic bit decode_byte(input mrr_req_t r, output bit taken, output mrr_res_t res);
		logic [2:0] ev;
		res = NO_RES;
		taken = 1'b0;
		if (frame_pos == STEP_IDLE) begin
			if (r.line_quiet && !r.tx_busy && r.rx_byte == station_id) begin
				taken = 1'b1;
				frame_buf[0] = r.rx_byte;
				crc_acc = crc16_shift(CRC_INIT, r.rx_byte);
				frame_pos = STEP_IDLE + 1'b1;
			end
			return 1'b0;
		end
		taken = 1'b1;
		frame_buf[frame_pos] = r.rx_byte;
		if (frame_pos < STEP_CRC_LO) begin
			crc_acc = crc16_shift(crc_acc, r.rx_byte);
			frame_pos = frame_pos + 1'b1;
			return 1'b0;
		end
		if (frame_pos == STEP_CRC_LO) begin
			if (crc_acc[7:0] == r.rx_byte) begin
				frame_pos = frame_pos + 1'b1;
				return 1'b0;
			end
			ev = EV_CRC;
		end else if (crc_acc[15:8] != r.rx_byte) begin
			ev = EV_CRC;
		end else if ({frame_buf[2], frame_buf[3]} == 16'h0000) begin
			ev = EV_ZERO;
		end else if (frame_buf[1] inside {FUNC_READ_HOLDING, FUNC_READ_INPUT}) begin
			ev = ({frame_buf[4], frame_buf[5]} == READ_COUNT_1) ? EV_READ : EV_OTHER;
		end else if (frame_buf[1] == FUNC_WRITE_SINGLE) begin
			ev = EV_WRITE;
		end else begin
			ev = EV_OTHER;
		end
		res = {ev, frame_buf[1], frame_buf[2], frame_buf[3], frame_buf[4], frame_buf[5]};
		frame_pos = STEP_IDLE;
		crc_acc = CRC_INIT;
		return 1'b1;
	endfunction

	// mostly well-formed frames with random content, some noise and CRC faults
	function automatic mrr_req_t random_request();
		mrr_req_t r;
		int roll;
		r.rx_byte = 8'($urandom);
		r.line_quiet = 1'($urandom);
		r.tx_busy = 1'($urandom);
		if (frame_pos == STEP_IDLE) begin
			zero_addr = ($urandom_range(0, 9) == 0);
			single_count = ($urandom_range(0, 9) < 6);
			roll = $urandom_range(0, 9);
			frame_fault = (roll == 0) ? FAULT_CRC_LO : (roll == 1) ? FAULT_CRC_HI : FAULT_NONE;
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				r.rx_byte = station_id;
				r.line_quiet = 1'b1;
				r.tx_busy = 1'b0;
			end else if (roll < 82) begin
				r.rx_byte = station_id;
				if (r.line_quiet) begin
					r.tx_busy = 1'b1;
				end
			end
		end else if (frame_pos == STEP_CRC_LO) begin
			r.rx_byte = crc_acc[7:0]
				^ ((frame_fault == FAULT_CRC_LO) ? 8'($urandom_range(1, 255)) : 8'h00);
		end else if (frame_pos == STEP_CRC_HI) begin
			r.rx_byte = crc_acc[15:8]
				^ ((frame_fault == FAULT_CRC_HI) ? 8'($urandom_range(1, 255)) : 8'h00);
		end else begin
			case (frame_pos)
				1: begin
					roll = $urandom_range(0, 9);
					if (roll < 3) begin
						r.rx_byte = FUNC_READ_HOLDING;
					end else if (roll < 5) begin
						r.rx_byte = FUNC_READ_INPUT;
					end else if (roll < 8) begin
						r.rx_byte = FUNC_WRITE_SINGLE;
					end
				end
				2, 3: begin
					if (zero_addr) begin
						r.rx_byte = 8'h00;
					end
				end
				4: begin
					if (single_count) begin
						r.rx_byte = READ_COUNT_1[15:8];
					end
				end
				default: begin
					if (single_count) begin
						r.rx_byte = READ_COUNT_1[7:0];
					end
				end
			endcase
		end
		return r;
	endfunction

	task automatic issue_request(input mrr_req_t r, input logic typed, input mrr_res_t typed_res);
		bit taken;
		bit closes;
		mrr_res_t res;
		int gap;
		closes = decode_byte(r, taken, res);
		if (typed) begin
			expected_events.push_back(typed_res);
		end else if (closes) begin
			expected_events.push_back(res);
		end
		if (taken) begin
			bytes_in_frames++;
		end
		gap = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do begin
			@(posedge clk);
		end while (req_stall);
	endtask

	task automatic write_slave_id(input logic [7:0] id);
		req_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= id;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		station_id = id;
	endtask

	always @(posedge clk) begin : result_check
		mrr_res_t want;
		if (res_valid && !res_stall) begin
			if (expected_events.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX) begin
					$display("unexpected result: event %0d func %02h addr %04h data %04h",
						res_data.event_res, res_data.function_code,
						res_data.register_address, res_data.data_value);
				end
			end else begin
				want = expected_events.pop_front();
				if (res_data.event_res !== want.event_res
						|| res_data.function_code !== want.function_code
						|| res_data.register_address !== want.register_address
						|| res_data.data_value !== want.data_value) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("result mismatch: expected event %0d func %02h addr %04h data %04h",
							want.event_res, want.function_code,
							want.register_address, want.data_value);
						$display("                 got      event %0d func %02h addr %04h data %04h",
							res_data.event_res, res_data.function_code,
							res_data.register_address, res_data.data_value);
					end
				end
			end
			res_hold = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
		end else if (res_hold != 0) begin
			res_hold--;
		end
		res_stall <= (res_hold != 0);
	end

	initial begin : watchdog
		int idle_run;
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_run = 0;
			end else begin
				idle_run++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] phase_ids [PHASES];
		dir_row_t row;
		mrr_req_t r;
		phase_ids = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'($urandom)};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			r = {row.rx_byte, row.line_quiet, row.tx_busy};
			if (row.src == SRC_CRC_LO) begin
				r.rx_byte = crc_acc[7:0] ^ row.rx_byte;
			end else if (row.src == SRC_CRC_HI) begin
				r.rx_byte = crc_acc[15:8] ^ row.rx_byte;
			end
			issue_request(r, row.typed, row.res);
		end

		// odd phases run back to back with no gaps or stalls
		for (int p = 0; p < PHASES; p++) begin
			write_slave_id(phase_ids[p]);
			pace_on = (p % 2 == 0);
			bytes_in_frames = 0;
			while (bytes_in_frames < PHASE_BYTES || frame_pos != STEP_IDLE) begin
				issue_request(random_request(), 1'b0, NO_RES);
			end
		end

		req_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_events.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
